FILE: hdl/nine_bit_serial_run_length_deframer_unit_defines.svh
// Assertion macros for the nine-bit serial run-length deframer.
// Included by the RTL files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef NINE_BIT_SERIAL_RUN_LENGTH_DEFRAMER_UNIT_DEFINES_SVH
`define NINE_BIT_SERIAL_RUN_LENGTH_DEFRAMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NBSRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("nbsrd assertion failed");
`define NBSRD_ASSERT_NEVER(lbl, cond) `NBSRD_ASSERT(lbl, !(cond))
`else
`define NBSRD_ASSERT(lbl, prop)
`define NBSRD_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: hdl/nbsrd_pkg.sv
// Shared types, constants and helpers of the nine-bit serial run-length deframer.
// No dependencies.
`default_nettype none
package nbsrd_pkg;

  localparam int unsigned CHAR_BITS    = 11;
  localparam int unsigned BIT_CNT_W    = 4;
  localparam int unsigned RUN_CNT_W    = 8;
  localparam int unsigned DUR_W        = 15;
  localparam int unsigned BT_W         = 10;
  localparam int unsigned NUM_W        = 16;
  localparam int unsigned FIELD_W      = 5;
  localparam int unsigned BASE_LEN     = 3;
  localparam int unsigned BT_RESET     = 208;
  localparam int unsigned REG_BIT_TIME = 0;
  localparam logic [RUN_CNT_W-1:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [CHAR_BITS-1:0] shift;
    logic [BIT_CNT_W-1:0] bit_cnt;
    logic [RUN_CNT_W-1:0] rem;
    logic                 full;
    logic [7:0]           byte_val;
  } char_step_t;

  // Reverse bit order of a byte.
  function automatic logic [7:0] flip8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/nbsrd_div.sv
// Restoring divider, one quotient bit per cycle; quotient saturates at 255.
// Depends on nbsrd_pkg.
`default_nettype none
module nbsrd_div
  import nbsrd_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [NUM_W-1:0]     num_i,
  input  wire logic [BT_W-1:0]      den_i,
  output logic                      done_o,
  output logic [RUN_CNT_W-1:0]      quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] num_q;
  logic [BT_W-1:0]  rem_q;
  logic [BT_W-1:0]  den_q;

  logic [BT_W:0] trial;
  logic [BT_W:0] diff;
  logic          ge;

  always_comb begin
    trial = {rem_q, num_q[NUM_W-1]};
    ge    = (trial >= {1'b0, den_q});
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= '0;
      rem_q  <= '0;
      den_q  <= BT_W'(1);
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      num_q  <= num_i;
      rem_q  <= '0;
      // a zero bit time acts as one
      den_q  <= (den_i == '0) ? BT_W'(1) : den_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[BT_W-1:0] : trial[BT_W-1:0];
      num_q  <= {num_q[NUM_W-2:0], ge};
      cnt_q  <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign done_o = done_q;
  assign quo_o  = (|num_q[NUM_W-1:RUN_CNT_W]) ? COUNT_MAX : num_q[RUN_CNT_W-1:0];

endmodule
`default_nettype wire

FILE: hdl/nbsrd_char.sv
// Character shift unit: moves as many run bits as fit into the character register
// in one step and decodes the byte of a full character. Depends on nbsrd_pkg.
`default_nettype none
module nbsrd_char
  import nbsrd_pkg::*;
(
  input  wire logic [CHAR_BITS-1:0] shift_i,
  input  wire logic [BIT_CNT_W-1:0] bit_cnt_i,
  input  wire logic [RUN_CNT_W-1:0] rem_i,
  input  wire logic                 lvl_i,
  output char_step_t                step_o
);

  logic [BIT_CNT_W-1:0] need;
  logic [BIT_CNT_W-1:0] take;
  logic [CHAR_BITS-1:0] fill;
  logic [CHAR_BITS-1:0] shifted;

  always_comb begin
    need = BIT_CNT_W'(CHAR_BITS) - bit_cnt_i;
    take = (rem_i < {{(RUN_CNT_W-BIT_CNT_W){1'b0}}, need}) ? rem_i[BIT_CNT_W-1:0] : need;
    fill = lvl_i ? ~({CHAR_BITS{1'b1}} << take) : '0;
    shifted = (shift_i << take) | fill;

    step_o.shift    = shifted;
    step_o.bit_cnt  = bit_cnt_i + take;
    step_o.rem      = rem_i - {{(RUN_CNT_W-BIT_CNT_W){1'b0}}, take};
    step_o.full     = (step_o.bit_cnt == BIT_CNT_W'(CHAR_BITS));
    step_o.byte_val = flip8(~shifted[9:2]);
  end

endmodule
`default_nettype wire

FILE: hdl/nine_bit_serial_run_length_deframer_unit.sv
// Nine-bit serial run-length deframer: line runs in, bytes of completed frames out.
// Each run is accepted in idle, passes the bit-time divider, then the character steps;
// a timeout skips the divider. A new request is taken only back in idle, after the run
// and any frame emission; a frame goes out one byte a cycle while the receiver is ready.
// Reset: control state and sync clear, bit time goes to 208 us; the frame store holds
// undefined data until written and needs no clearing pass.
`default_nettype none
`include "nine_bit_serial_run_length_deframer_unit_defines.svh"
module nine_bit_serial_run_length_deframer_unit
  import nbsrd_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 18
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [0] level, [15:1] duration_us
  input  wire logic [0:0]  s_axis_tuser,   // [0] func
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [7:0] frame_byte, [12:8] byte_index,
                                           // [17:13] frame_length, [23:18] zero
  output logic             m_axis_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned ADDR_W = $clog2(MAX_FRAME_BYTES);
  localparam int unsigned IDX_W  = $clog2(MAX_FRAME_BYTES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_CHAR,
    S_EMIT
  } state_e;

  // Sequencer and line state
  state_e               state_q, state_d;
  logic [BT_W-1:0]      bit_time_q, bit_time_d;
  logic [CHAR_BITS-1:0] char_shift_q, char_shift_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic                 in_frame_q, in_frame_d;
  logic [FIELD_W-1:0]   exp_len_q, exp_len_d;
  logic [IDX_W-1:0]     char_idx_q, char_idx_d;
  logic                 lvl_q, lvl_d;
  logic                 tmo_q, tmo_d;
  logic [RUN_CNT_W-1:0] rem_q, rem_d;
  logic [ADDR_W-1:0]    emit_idx_q, emit_idx_d;
  logic [FIELD_W-1:0]   frame_len_q, frame_len_d;

  // Output register
  logic                 m_valid_q, m_valid_d;
  logic [7:0]           m_byte_q, m_byte_d;
  logic [FIELD_W-1:0]   m_idx_q, m_idx_d;
  logic [FIELD_W-1:0]   m_len_q, m_len_d;
  logic                 m_last_q, m_last_d;

  // Frame store: written during character steps, read at the emit pointer
  logic [7:0]           frame_store_q [MAX_FRAME_BYTES];
  logic                 store_we;
  logic [ADDR_W-1:0]    store_addr;
  logic [7:0]           store_wdata;

  logic                 in_fire;
  logic                 cfg_write;
  logic                 in_func;
  logic                 in_level;
  logic [DUR_W-1:0]     in_dur;
  logic                 div_start;
  logic                 div_done;
  logic [RUN_CNT_W-1:0] div_quo;
  logic [NUM_W-1:0]     div_num;
  char_step_t           step;
  logic [FIELD_W-1:0]   exp_len_new;
  logic [IDX_W-1:0]     char_idx_new;
  logic [FIELD_W:0]     emit_next;

  assign in_func  = s_axis_tuser[0];
  assign in_level = s_axis_tdata[0];
  assign in_dur   = s_axis_tdata[15:1];
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // Configuration: one register, decoded on the word address bit
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'(REG_BIT_TIME)) ? {{(32-BT_W){1'b0}}, bit_time_q} : '0;

  // Rounded bit count: (duration + half bit) / bit time
  assign div_num = {1'b0, in_dur} + {{(NUM_W-BT_W+1){1'b0}}, bit_time_q[BT_W-1:1]};

  nbsrd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (bit_time_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  nbsrd_char u_char (
    .shift_i   (char_shift_q),
    .bit_cnt_i (bit_cnt_q),
    .rem_i     (rem_q),
    .lvl_i     (lvl_q),
    .step_o    (step)
  );

  // The second character's low nibble extends the base length
  assign exp_len_new  = (char_idx_q == IDX_W'(1))
                      ? exp_len_q + {1'b0, step.byte_val[3:0]} : exp_len_q;
  assign char_idx_new = char_idx_q + IDX_W'(1);
  assign emit_next    = {1'b0, FIELD_W'(emit_idx_q)} + (FIELD_W+1)'(1);

  always_comb begin
    state_d      = state_q;
    bit_time_d   = bit_time_q;
    char_shift_d = char_shift_q;
    bit_cnt_d    = bit_cnt_q;
    in_frame_d   = in_frame_q;
    exp_len_d    = exp_len_q;
    char_idx_d   = char_idx_q;
    lvl_d        = lvl_q;
    tmo_d        = tmo_q;
    rem_d        = rem_q;
    emit_idx_d   = emit_idx_q;
    frame_len_d  = frame_len_q;
    m_valid_d    = m_valid_q;
    m_byte_d     = m_byte_q;
    m_idx_d      = m_idx_q;
    m_len_d      = m_len_q;
    m_last_d     = m_last_q;
    div_start    = 1'b0;
    store_we     = 1'b0;
    store_addr   = char_idx_q[ADDR_W-1:0];
    store_wdata  = step.byte_val;

    if (cfg_write && (paddr[2] == 1'(REG_BIT_TIME))) begin
      bit_time_d = pwdata[BT_W-1:0];
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_func) begin
            // Timeout: pad the open character with low bits, then drop sync
            if (in_frame_q) begin
              lvl_d   = 1'b0;
              tmo_d   = 1'b1;
              rem_d   = RUN_CNT_W'(BIT_CNT_W'(CHAR_BITS) - bit_cnt_q);
              state_d = S_CHAR;
            end
          end else if ((in_dur != '0) && (in_frame_q || in_level)) begin
            if (!in_frame_q) begin
              // High run out of sync opens a frame, even if it rounds to no bits
              in_frame_d   = 1'b1;
              exp_len_d    = FIELD_W'(BASE_LEN);
              char_idx_d   = '0;
              bit_cnt_d    = '0;
              char_shift_d = '0;
            end
            lvl_d     = in_level;
            tmo_d     = 1'b0;
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (div_done) begin
          rem_d   = div_quo;
          state_d = S_CHAR;
        end
      end

      S_CHAR: begin
        char_shift_d = step.shift;
        bit_cnt_d    = step.bit_cnt;
        rem_d        = step.rem;
        if (!step.full) begin
          // run exhausted mid-character
          state_d = S_IDLE;
        end else begin
          exp_len_d = exp_len_new;
          if (char_idx_q >= IDX_W'(MAX_FRAME_BYTES)) begin
            // overlong frame: discard, drop sync and the rest of the run
            in_frame_d   = 1'b0;
            char_idx_d   = '0;
            char_shift_d = '0;
            bit_cnt_d    = '0;
            state_d      = S_IDLE;
          end else begin
            store_we     = 1'b1;
            char_idx_d   = char_idx_new;
            char_shift_d = '0;
            bit_cnt_d    = '0;
            if ((FIELD_W+1)'(exp_len_new) == (FIELD_W+1)'(char_idx_new)) begin
              // frame complete: drop sync, discard leftover bits, emit
              frame_len_d = FIELD_W'(char_idx_new);
              emit_idx_d  = '0;
              in_frame_d  = 1'b0;
              char_idx_d  = '0;
              state_d     = S_EMIT;
            end else if (tmo_q) begin
              in_frame_d  = 1'b0;
              char_idx_d  = '0;
              state_d     = S_IDLE;
            end else if (!lvl_q || (step.rem == '0)) begin
              // a low bit ends a character; its run ends here too
              state_d = S_IDLE;
            end
          end
        end
      end

      S_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          if (m_valid_q && m_last_q) begin
            m_valid_d = 1'b0;
            state_d   = S_IDLE;
          end else begin
            m_valid_d  = 1'b1;
            m_byte_d   = frame_store_q[emit_idx_q];
            m_idx_d    = FIELD_W'(emit_idx_q);
            m_len_d    = frame_len_q;
            m_last_d   = (emit_next == {1'b0, frame_len_q});
            emit_idx_d = emit_idx_q + ADDR_W'(1);
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      bit_time_q   <= BT_W'(BT_RESET);
      char_shift_q <= '0;
      bit_cnt_q    <= '0;
      in_frame_q   <= 1'b0;
      exp_len_q    <= FIELD_W'(BASE_LEN);
      char_idx_q   <= '0;
      lvl_q        <= 1'b0;
      tmo_q        <= 1'b0;
      rem_q        <= '0;
      emit_idx_q   <= '0;
      frame_len_q  <= '0;
      m_valid_q    <= 1'b0;
      m_byte_q     <= '0;
      m_idx_q      <= '0;
      m_len_q      <= '0;
      m_last_q     <= 1'b0;
    end else begin
      state_q      <= state_d;
      bit_time_q   <= bit_time_d;
      char_shift_q <= char_shift_d;
      bit_cnt_q    <= bit_cnt_d;
      in_frame_q   <= in_frame_d;
      exp_len_q    <= exp_len_d;
      char_idx_q   <= char_idx_d;
      lvl_q        <= lvl_d;
      tmo_q        <= tmo_d;
      rem_q        <= rem_d;
      emit_idx_q   <= emit_idx_d;
      frame_len_q  <= frame_len_d;
      m_valid_q    <= m_valid_d;
      m_byte_q     <= m_byte_d;
      m_idx_q      <= m_idx_d;
      m_len_q      <= m_len_d;
      m_last_q     <= m_last_d;
    end
  end

  // Hold frame bytes; no reset, only entries of the current frame are read
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      frame_store_q[store_addr] <= store_wdata;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tdata  = {6'b0, m_len_q, m_idx_q, m_byte_q};

  `NBSRD_ASSERT(a_ready_no_result, s_axis_tready |-> !m_axis_tvalid)
  `NBSRD_ASSERT(a_last_ends_frame, (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> !m_axis_tvalid)
  `NBSRD_ASSERT(a_index_in_length, m_axis_tvalid |-> (m_idx_q < m_len_q))
  `NBSRD_ASSERT_NEVER(a_idle_char_open, (state_q == S_IDLE) && (bit_cnt_q >= BIT_CNT_W'(CHAR_BITS)))
  `NBSRD_ASSERT_NEVER(a_unsync_dirty, !in_frame_q && ((bit_cnt_q != '0) || (char_idx_q != '0)))

endmodule
`default_nettype wire

FILE: test/testbench.sv
// Testbench for the nine-bit serial run-length deframer: line runs and idle timeouts go in,
// the bytes of each completed frame are predicted here and checked field by field.
// Depends on nbsrd_pkg and nine_bit_serial_run_length_deframer_unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import nbsrd_pkg::*;

  localparam int FRAME_MAX     = 18;
  localparam int MAX_DUR       = 32767;
  localparam int RUN_BITS_MAX  = 255;
  localparam int SETTLE_CYCLES = 64;    // well above the worst run latency of the block
  localparam int QUIET_LIMIT   = 3000;  // cycles without any accepted request
  localparam int RANDOM_ITEMS  = 440;
  localparam int N_PHASES      = 6;
  localparam int N_DIR         = 24;
  localparam int FROM_MODEL    = -1;    // row checked against the predictor only

  localparam logic FN_RUN     = 1'b0;
  localparam logic FN_TIMEOUT = 1'b1;
  localparam logic LINE_LOW   = 1'b0;
  localparam logic LINE_HIGH  = 1'b1;
  localparam logic [2:0] BIT_TIME_ADDR = 3'(4 * REG_BIT_TIME);

  typedef struct packed {
    logic        func;
    logic        level;
    logic [14:0] dur;
  } run_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic [4:0] index;
    logic [4:0] length;
    logic       last;
  } frame_byte_t;

  typedef struct packed {
    logic        func;
    logic        level;
    logic [14:0] dur;
    int          typed_n;    // bytes emitted by this row, or FROM_MODEL
    logic [7:0]  typed_val;  // every emitted byte has this value
  } dir_row_t;

  // Clock, reset and all block inputs start at known values.
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  nine_bit_serial_run_length_deframer_unit #(
    .MAX_FRAME_BYTES(FRAME_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #1 clk_i = ~clk_i;

  // Bytes still owed by the block, oldest first, and the bytes of the latest request.
  frame_byte_t due_bytes[$];
  frame_byte_t fresh_bytes[$];

  int errors      = 0;
  int items_sent  = 0;
  int burst_left  = 0;
  bit steady      = 1'b0;
  int quiet_count = 0;
  int rx_cycle    = 0;

  // Shadow of the deframer state.
  logic [9:0]  bit_period  = 10'(BT_RESET);
  logic [10:0] line_shift  = '0;
  int          bits_held   = 0;
  bit          synced      = 1'b0;
  logic [4:0]  goal_len    = 5'(BASE_LEN);
  int          chars_taken = 0;
  logic [7:0]  frame_buf [FRAME_MAX];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 40) begin
      $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    end
  endtask

  function automatic void lose_sync();
    synced      = 1'b0;
    chars_taken = 0;
    line_shift  = '0;
    bits_held   = 0;
  endfunction

  // Take a full character; return 1 when the rest of the run must be dropped.
  function automatic bit take_char();
    logic [7:0]  inv;
    logic [7:0]  val;
    frame_byte_t fb;
    // Data travels inverted and LSB first: reverse the inverted middle byte.
    inv = ~line_shift[9:2];
    for (int i = 0; i < 8; i++) begin
      val[i] = inv[7-i];
    end
    // The second character carries the length nibble.
    if (chars_taken == 1) goal_len = goal_len + 5'(val[3:0]);
    if (chars_taken >= FRAME_MAX) begin
      lose_sync();
      return 1'b1;
    end
    frame_buf[chars_taken] = val;
    chars_taken++;
    line_shift = '0;
    bits_held  = 0;
    if (int'(goal_len) == chars_taken) begin
      for (int i = 0; i < chars_taken; i++) begin
        fb.value  = frame_buf[i];
        fb.index  = 5'(i);
        fb.length = 5'(chars_taken);
        fb.last   = (i == chars_taken - 1);
        fresh_bytes.push_back(fb);
      end
      lose_sync();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void shift_bits(input logic lvl, input int count);
    if (!synced) begin
      // Only a mark level opens a frame.
      if (!lvl) return;
      synced      = 1'b1;
      goal_len    = 5'(BASE_LEN);
      chars_taken = 0;
      bits_held   = 0;
      line_shift  = '0;
    end
    for (int k = 0; k < count; k++) begin
      line_shift = {line_shift[9:0], lvl};
      bits_held++;
      if (bits_held >= int'(CHAR_BITS)) begin
        if (take_char()) return;
        // A character cannot start low: drop the rest of a low run.
        if (!lvl) return;
      end
    end
  endfunction

  function automatic int period_us();
    return (bit_period == '0) ? 1 : int'(bit_period);
  endfunction

  function automatic void deframe_run(input run_req_t req);
    int count;
    fresh_bytes.delete();
    if (req.func == FN_TIMEOUT) begin
      if (synced) begin
        shift_bits(LINE_LOW, int'(CHAR_BITS) - bits_held);
        lose_sync();
      end
      return;
    end
    if (req.dur != '0) begin
      count = (int'(req.dur) + period_us() / 2) / period_us();
      if (count > RUN_BITS_MAX) count = RUN_BITS_MAX;
      shift_bits(req.level, count);
    end
  endfunction

  // Present one request after an optional gap, hold it until taken, then predict.
  task automatic drive_run(input logic fn, input logic lvl, input int dur, input int typed_n,
                           input logic [7:0] typed_val);
    run_req_t    req;
    frame_byte_t fb;
    int          pause;
    req.func  = fn;
    req.level = lvl;
    req.dur   = 15'(dur);
    pause     = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady) pause = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk_i);
    if (pause > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {req.dur, req.level};
    s_axis_tuser  <= req.func;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    deframe_run(req);
    if (typed_n == FROM_MODEL) begin
      foreach (fresh_bytes[i]) due_bytes.push_back(fresh_bytes[i]);
    end else begin
      for (int i = 0; i < typed_n; i++) begin
        fb.value  = typed_val;
        fb.index  = 5'(i);
        fb.length = 5'(typed_n);
        fb.last   = (i == typed_n - 1);
        due_bytes.push_back(fb);
      end
    end
  endtask

  task automatic rest_sender();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait for every owed byte, then let any run that gives no byte finish.
  task automatic settle();
    while (due_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_bit_time(input logic [9:0] value);
    logic [31:0] rdata;
    settle();
    apb_access(1'b1, BIT_TIME_ADDR, 32'(value), rdata);
    bit_period = value;
    apb_access(1'b0, BIT_TIME_ADDR, '0, rdata);
    if (rdata[BT_W-1:0] != value) report_mismatch("bit_time_us readback", rdata, 32'(value));
  endtask

  // Duration of a run of nbits bit periods, jittered within the rounding window.
  function automatic int run_duration(input int nbits);
    int dur;
    dur = nbits * period_us() + int'($urandom_range(0, period_us() - 1)) - period_us() / 2;
    if (dur > MAX_DUR) dur = MAX_DUR;
    return dur;
  endfunction

  // Send one well-formed frame with random content; spoil a few of them.
  task automatic send_frame();
    bit         line[$];
    int         n_chars;
    int         c;
    int         b;
    int         i;
    int         cut;
    int         run_len;
    logic       run_lvl;
    logic [7:0] val;
    bit         cut_short;
    n_chars = ($urandom_range(0, 3) == 0) ? $urandom_range(3, 18) : $urandom_range(3, 6);
    for (c = 0; c < n_chars; c++) begin
      val = 8'($urandom_range(0, 255));
      if (c == 1) val[3:0] = 4'(n_chars - int'(BASE_LEN));
      line.push_back(1'b1);
      for (b = 0; b < 8; b++) line.push_back(~val[b]);
      line.push_back(1'($urandom_range(0, 1)));
      line.push_back(1'($urandom_range(0, 1)));
    end
    cut_short = 1'b0;
    case ($urandom_range(0, 9))
      0: begin
        // corrupt one bit
        i = $urandom_range(0, line.size() - 1);
        line[i] = ~line[i];
      end
      1: begin
        // stop mid-frame and let the line time out
        cut = $urandom_range(1, line.size() - 1);
        while (line.size() > cut) line.delete(line.size() - 1);
        cut_short = 1'b1;
      end
      default: ;
    endcase
    i = 0;
    while (i < line.size()) begin
      run_lvl = line[i];
      run_len = 0;
      while (i < line.size() && line[i] == run_lvl) begin
        run_len++;
        i++;
      end
      drive_run(FN_RUN, run_lvl, run_duration(run_len), FROM_MODEL, 8'h00);
    end
    if (cut_short) begin
      drive_run(FN_TIMEOUT, 1'($urandom_range(0, 1)), $urandom_range(0, MAX_DUR), FROM_MODEL,
                8'h00);
    end
  endtask

  // Send one request with arbitrary content.
  task automatic send_noise();
    int dur;
    case ($urandom_range(0, 3))
      0:       dur = $urandom_range(0, MAX_DUR);
      1:       dur = $urandom_range(0, 3 * period_us());
      2:       dur = 0;
      default: dur = MAX_DUR - int'($urandom_range(0, 7));
    endcase
    drive_run(($urandom_range(0, 4) == 0) ? FN_TIMEOUT : FN_RUN, 1'($urandom_range(0, 1)),
              dur, FROM_MODEL, 8'h00);
  endtask

  // Directed rows, all at the reset bit time of 208 us.
  dir_row_t dir_rows [N_DIR] = '{
    // out of sync: timeout, low runs and a zero-length high run leave nothing behind
    '{FN_TIMEOUT, LINE_LOW,  15'd0,     0, 8'h00},
    '{FN_RUN,     LINE_LOW,  15'd1000,  0, 8'h00},
    '{FN_RUN,     LINE_HIGH, 15'd0,     0, 8'h00},
    '{FN_RUN,     LINE_LOW,  15'd32767, 0, 8'h00},
    // short high run resyncs without bits, a short low run adds none, timeout pads one char
    '{FN_RUN,     LINE_HIGH, 15'd50,    0, 8'h00},
    '{FN_RUN,     LINE_LOW,  15'd50,    0, 8'h00},
    '{FN_TIMEOUT, LINE_LOW,  15'd0,     0, 8'h00},
    // three characters of 0xF0, length nibble zero: H5 L4 H7 L4 H7 L4 H2
    '{FN_RUN,     LINE_HIGH, 15'd1040,  0, 8'h00},
    '{FN_RUN,     LINE_LOW,  15'd832,   0, 8'h00},
    '{FN_RUN,     LINE_HIGH, 15'd1456,  0, 8'h00},
    '{FN_RUN,     LINE_LOW,  15'd832,   0, 8'h00},
    '{FN_RUN,     LINE_HIGH, 15'd1456,  0, 8'h00},
    '{FN_RUN,     LINE_LOW,  15'd832,   0, 8'h00},
    '{FN_RUN,     LINE_HIGH, 15'd416,   3, 8'hF0},
    // longest high run: three 0x00 characters, the rest of the run is discarded
    '{FN_RUN,     LINE_HIGH, 15'd32767, 3, 8'h00},
    // timeout part way into the first character
    '{FN_RUN,     LINE_HIGH, 15'd416,   0, 8'h00},
    '{FN_TIMEOUT, LINE_HIGH, 15'd32767, 0, 8'h00},
    // two characters, then a timeout pads the third and completes the frame
    '{FN_RUN,     LINE_HIGH, 15'd4576,  0, 8'h00},
    '{FN_TIMEOUT, LINE_LOW,  15'd0,     FROM_MODEL, 8'h00},
    // a low bit ends a character and the rest of that low run is dropped
    '{FN_RUN,     LINE_HIGH, 15'd208,   0, 8'h00},
    '{FN_RUN,     LINE_LOW,  15'd4160,  0, 8'h00},
    '{FN_RUN,     LINE_HIGH, 15'd4576,  FROM_MODEL, 8'h00},
    '{FN_RUN,     LINE_LOW,  15'd0,     0, 8'h00},
    '{FN_TIMEOUT, LINE_HIGH, 15'd1,     0, 8'h00}
  };

  // Receiver: cycle through always ready, random stalls and a fixed stall pattern.
  always @(negedge clk_i) begin
    rx_cycle++;
    case ((rx_cycle / 250) % 4)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready <= ((rx_cycle % 7) < 4);
      default: m_axis_tready <= 1'($urandom_range(0, 1));
    endcase
  end

  // Compare each accepted output request with the oldest owed byte.
  always @(posedge clk_i) begin
    frame_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (due_bytes.size() == 0) begin
        report_mismatch("byte with nothing owed", 32'(m_axis_tdata), '0);
      end else begin
        want = due_bytes.pop_front();
        if (m_axis_tdata[7:0] != want.value)
          report_mismatch("frame_byte", 32'(m_axis_tdata[7:0]), 32'(want.value));
        if (m_axis_tdata[12:8] != want.index)
          report_mismatch("byte_index", 32'(m_axis_tdata[12:8]), 32'(want.index));
        if (m_axis_tdata[17:13] != want.length)
          report_mismatch("frame_length", 32'(m_axis_tdata[17:13]), 32'(want.length));
        if (m_axis_tdata[23:18] != '0)
          report_mismatch("tdata padding", 32'(m_axis_tdata[23:18]), '0);
        if (m_axis_tlast != want.last)
          report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
      end
    end
  end

  // Watchdog: stop a run in which no request of any kind gets through.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      quiet_count <= 0;
    end else if (quiet_count >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    logic [31:0] rdata;
    int          plan [N_PHASES];
    int          phase_end;
    plan = '{1, 1023, 0, 37, 208, 208};
    plan[4] = $urandom_range(2, 400);

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The bit time must read back its reset value.
    apb_access(1'b0, BIT_TIME_ADDR, '0, rdata);
    if (rdata[BT_W-1:0] != BT_W'(BT_RESET))
      report_mismatch("bit_time_us after reset", rdata, 32'(BT_RESET));

    steady = 1'b1;
    foreach (dir_rows[r]) begin
      drive_run(dir_rows[r].func, dir_rows[r].level, int'(dir_rows[r].dur), dir_rows[r].typed_n,
                dir_rows[r].typed_val);
    end
    rest_sender();

    // Random frames and noise under each bit time, the extremes among them.
    for (int p = 0; p < N_PHASES; p++) begin
      set_bit_time(10'(plan[p]));
      phase_end = items_sent + RANDOM_ITEMS / N_PHASES;
      while (items_sent < phase_end) begin
        steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) begin
          send_noise();
        end else begin
          send_frame();
          case ($urandom_range(0, 2))
            0: drive_run(FN_RUN, LINE_LOW, $urandom_range(1, MAX_DUR), FROM_MODEL, 8'h00);
            1: drive_run(FN_TIMEOUT, LINE_LOW, 0, FROM_MODEL, 8'h00);
            default: ;
          endcase
        end
      end
      rest_sender();
    end

    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
